// File: hw/rtl/mme_pkg.sv
// Shared types and constants for the matrix multiply engine.
package mme_pkg;

    // Field widths
    localparam int FUNC_W    = 2;
    localparam int IDX_W     = 4;
    localparam int ELEM_W    = 16;
    localparam int PROD_W    = 2 * ELEM_W;
    localparam int SUM_W     = 36;
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 1;
    localparam int MAX_OUT   = 16;

    // Stream data widths; the result width is padded to whole bytes
    localparam int S_TDATA_W = 2 * IDX_W + ELEM_W;
    localparam int M_FIELD_W = 2 * IDX_W + SUM_W;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;
    localparam int M_PAD_W   = M_TDATA_W - M_FIELD_W;

    // Request kinds carried in tuser
    localparam logic [FUNC_W-1:0] FUNC_WRITE_A = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WRITE_B = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_COMPUTE = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_LENGTH   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_COLUMNS = 1'b1;

    // Control that travels alongside each operand pair into the MAC unit
    typedef struct packed {
        logic vld;
        logic first;
        logic last;
    } mac_ctl_t;

    // Result load command from the sequencer to the output register
    typedef struct packed {
        logic             load;
        logic             zero;
        logic             last;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } emit_t;

endpackage

// File: hw/rtl/mme_mac.sv
// Shared multiply-accumulate unit: registered product, then 36-bit accumulator.
module mme_mac
    import mme_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  mac_ctl_t                 ctl,
    input  logic signed [ELEM_W-1:0] a_data,
    input  logic signed [ELEM_W-1:0] b_data,
    output logic signed [SUM_W-1:0]  sum,
    output logic                     done
);

    logic signed [PROD_W-1:0] prod_reg;
    mac_ctl_t                 prod_ctl_reg;
    logic signed [SUM_W-1:0]  acc_reg;
    logic signed [SUM_W-1:0]  acc_next;
    logic signed [SUM_W-1:0]  prod_ext;
    logic                     done_reg;

    // Sign-extend the product and add; the sum wraps at 36 bits
    assign prod_ext = {{(SUM_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    assign acc_next = prod_ctl_reg.first ? prod_ext : (acc_reg + prod_ext);

    // Multiply stage
    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(a_data) * PROD_W'(b_data);
    end

    // Accumulate stage: hold the sum between columns
    always_ff @(posedge clk)
    begin
        if (prod_ctl_reg.vld)
        begin
            acc_reg <= acc_next;
        end
    end

    // Control pipeline and column-done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_ctl_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            prod_ctl_reg <= ctl;
            done_reg     <= prod_ctl_reg.vld && prod_ctl_reg.last;
        end
    end

    assign sum  = acc_reg;
    assign done = done_reg;

endmodule

// File: hw/rtl/mme_seq.sv
// Sequencer with the A and B element memories: loads elements, walks dot products.
module mme_seq
    import mme_pkg::*;
#(
    parameter int ROWS  = 16,
    parameter int INNER = 16,
    parameter int COLS  = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [FUNC_W-1:0]        func,
    input  logic [IDX_W-1:0]         row_index,
    input  logic [IDX_W-1:0]         col_index,
    input  logic signed [ELEM_W-1:0] element_value,
    input  logic [CFG_W-1:0]         len,
    input  logic [CFG_W-1:0]         ncols,
    input  logic                     out_free,
    input  logic                     mac_done,
    output logic signed [ELEM_W-1:0] a_data,
    output logic signed [ELEM_W-1:0] b_data,
    output mac_ctl_t                 rd_ctl,
    output emit_t                    emit
);

    localparam int A_DEPTH = ROWS * INNER;
    localparam int B_DEPTH = INNER * COLS;
    localparam int A_AW    = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
    localparam int B_AW    = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;

    localparam logic [6:0] ROWS_L  = 7'(ROWS);
    localparam logic [6:0] INNER_L = 7'(INNER);
    localparam logic [6:0] COLS_L  = 7'(COLS);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic signed [ELEM_W-1:0] a_mem [A_DEPTH];
    logic signed [ELEM_W-1:0] b_mem [B_DEPTH];
    logic signed [ELEM_W-1:0] a_rd_reg;
    logic signed [ELEM_W-1:0] b_rd_reg;

    logic [1:0]       state_reg, state_next;
    logic [IDX_W-1:0] row_reg, row_next;
    logic [IDX_W-1:0] col_reg, col_next;
    logic [CFG_W-1:0] k_reg, k_next;
    mac_ctl_t         rd_ctl_reg;
    mac_ctl_t         issue_ctl;

    logic             accept;
    logic [6:0]       row_ext;
    logic [6:0]       col_ext;
    logic             a_wr_ok;
    logic             b_wr_ok;
    logic [A_AW-1:0]  wr_a_addr;
    logic [B_AW-1:0]  wr_b_addr;
    logic [A_AW-1:0]  rd_a_addr;
    logic [B_AW-1:0]  rd_b_addr;
    logic             k_last;
    logic             col_last;

    // Request decode and range checks
    assign accept  = s_tvalid && s_tready;
    assign row_ext = {3'b000, row_index};
    assign col_ext = {3'b000, col_index};
    assign a_wr_ok = (row_ext < ROWS_L) && (col_ext < INNER_L);
    assign b_wr_ok = (row_ext < INNER_L) && (col_ext < COLS_L);

    // Element addresses, row-major
    assign wr_a_addr = A_AW'(int'(row_index) * INNER + int'(col_index));
    assign wr_b_addr = B_AW'(int'(row_index) * COLS + int'(col_index));
    assign rd_a_addr = A_AW'(int'(row_reg) * INNER + int'(k_reg));
    assign rd_b_addr = B_AW'(int'(k_reg) * COLS + int'(col_reg));

    // Element memories: one write port, one registered read port each
    always_ff @(posedge clk)
    begin
        if (accept && (func == FUNC_WRITE_A) && a_wr_ok)
        begin
            a_mem[wr_a_addr] <= element_value;
        end
        if (accept && (func == FUNC_WRITE_B) && b_wr_ok)
        begin
            b_mem[wr_b_addr] <= element_value;
        end
        a_rd_reg <= a_mem[rd_a_addr];
        b_rd_reg <= b_mem[rd_b_addr];
    end

    // Term and column position
    assign k_last   = ((k_reg + 5'd1) == len);
    assign col_last = (({1'b0, col_reg} + 5'd1) == ncols);

    assign issue_ctl.vld   = (state_reg == ST_RUN);
    assign issue_ctl.first = (k_reg == '0);
    assign issue_ctl.last  = k_last;

    // Advance through terms, wait for the sum, hand it to the output stage
    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        k_next     = k_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (func == FUNC_COMPUTE) && (row_ext < ROWS_L) && (ncols != '0))
                begin
                    row_next   = row_index;
                    col_next   = '0;
                    k_next     = '0;
                    state_next = (len == '0) ? ST_EMIT : ST_RUN;
                end
            end
            ST_RUN:
            begin
                k_next = k_reg + 5'd1;
                if (k_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (mac_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    if (col_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        col_next   = col_reg + 4'd1;
                        k_next     = '0;
                        state_next = (len == '0) ? ST_EMIT : ST_RUN;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            row_reg    <= '0;
            col_reg    <= '0;
            k_reg      <= '0;
            rd_ctl_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            row_reg    <= row_next;
            col_reg    <= col_next;
            k_reg      <= k_next;
            rd_ctl_reg <= issue_ctl;
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign a_data    = a_rd_reg;
    assign b_data    = b_rd_reg;
    assign rd_ctl    = rd_ctl_reg;

    assign emit.load = (state_reg == ST_EMIT) && out_free;
    assign emit.zero = (len == '0);
    assign emit.last = col_last;
    assign emit.row  = row_reg;
    assign emit.col  = col_reg;

endmodule

// File: hw/rtl/matrix_multiply_engine.sv
// Top level of the matrix multiply engine: config registers, output register, core.
//
// Usage:
//   s_tuser carries the request kind: write one A element, write one B element,
//   or compute one row of C = A x B. s_tdata carries row, column and element.
//   A compute request returns one result per column on the m_ side, in
//   increasing column order, with m_tlast on the final column of the row.
//   cfg_wr_en/cfg_index/cfg_data set the inner length and the column count;
//   write them only while no compute request is in flight.
// Flow:
//   Element writes are accepted while no row is being computed. A compute
//   request runs one shared multiply-accumulate unit: each column feeds its
//   terms one per cycle, then the memory/multiply/accumulate pipeline drains
//   and the sum is loaded into the output register.
//   s_tready is low while a row is being computed.
// Reset and stall:
//   Reset sets both config registers to 16 and empties the output register;
//   element memories are not cleared. A stalled receiver holds the result in
//   the output register and the sequencer waits before loading the next one.
module matrix_multiply_engine
    import mme_pkg::*;
#(
    parameter int ROWS  = 16,
    parameter int INNER = 16,
    parameter int COLS  = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // row_index, col_index, element_value
    input  logic [FUNC_W-1:0]     s_tuser,   // func
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // out_row, out_col, sum_value, zero pad
    output logic                  m_tlast,   // last_of_row
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    localparam int         COL_LIM   = (COLS < MAX_OUT) ? COLS : MAX_OUT;
    localparam logic [6:0] INNER_L   = 7'(INNER);
    localparam logic [6:0] COL_LIM_L = 7'(COL_LIM);

    logic [CFG_W-1:0]         inner_length_reg;
    logic [CFG_W-1:0]         output_columns_reg;
    logic [CFG_W-1:0]         len;
    logic [CFG_W-1:0]         ncols;

    logic [IDX_W-1:0]         row_index;
    logic [IDX_W-1:0]         col_index;
    logic signed [ELEM_W-1:0] element_value;

    logic signed [ELEM_W-1:0] a_data;
    logic signed [ELEM_W-1:0] b_data;
    mac_ctl_t                 rd_ctl;
    logic signed [SUM_W-1:0]  mac_sum;
    logic                     mac_done;
    emit_t                    emit;
    logic                     out_free;

    logic                     m_valid_reg;
    logic [IDX_W-1:0]         m_row_reg;
    logic [IDX_W-1:0]         m_col_reg;
    logic signed [SUM_W-1:0]  m_sum_reg;
    logic                     m_last_reg;

    // Unpack the request
    assign row_index     = s_tdata[IDX_W-1:0];
    assign col_index     = s_tdata[2*IDX_W-1:IDX_W];
    assign element_value = s_tdata[S_TDATA_W-1:2*IDX_W];

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inner_length_reg   <= CFG_W'(16);
            output_columns_reg <= CFG_W'(16);
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_INNER_LENGTH:   inner_length_reg   <= cfg_data;
                CFG_OUTPUT_COLUMNS: output_columns_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Saturate the configured sizes to the array dimensions
    assign len   = ({2'b00, inner_length_reg} > INNER_L) ? INNER_L[CFG_W-1:0]
                                                         : inner_length_reg;
    assign ncols = ({2'b00, output_columns_reg} > COL_LIM_L) ? COL_LIM_L[CFG_W-1:0]
                                                             : output_columns_reg;

    assign out_free = !m_valid_reg || m_tready;

    mme_seq #(
        .ROWS  (ROWS),
        .INNER (INNER),
        .COLS  (COLS)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .func          (s_tuser),
        .row_index     (row_index),
        .col_index     (col_index),
        .element_value (element_value),
        .len           (len),
        .ncols         (ncols),
        .out_free      (out_free),
        .mac_done      (mac_done),
        .a_data        (a_data),
        .b_data        (b_data),
        .rd_ctl        (rd_ctl),
        .emit          (emit)
    );

    mme_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (rd_ctl),
        .a_data (a_data),
        .b_data (b_data),
        .sum    (mac_sum),
        .done   (mac_done)
    );

    // Output register: load a finished column, drop it once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (emit.load)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.load)
        begin
            m_row_reg  <= emit.row;
            m_col_reg  <= emit.col;
            m_sum_reg  <= emit.zero ? '0 : mac_sum;
            m_last_reg <= emit.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, m_sum_reg, m_col_reg, m_row_reg};
    assign m_tlast  = m_last_reg;

endmodule

// File: hw/rtl/mme_checker.sv
// Port-level checks for the matrix multiply engine, bound to the top level.
module mme_checker
    import mme_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [FUNC_W-1:0]    s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tlast
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // Load a new result only while a row is being computed
    a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared while idle");

    // Be ready for the next request in the cycle after an element write
    a_write_one: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == FUNC_WRITE_A || s_tuser == FUNC_WRITE_B)
        |=> s_tready)
        else $error("element write did not complete in one cycle");

    // Stay busy until the last column of the row is out
    a_row_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("request taken before the row finished");

endmodule

bind matrix_multiply_engine mme_checker u_mme_checker (.*);

// File: tb/tb_top.sv
// Self-checking testbench for the matrix multiply engine.
`timescale 1ns / 100ps

module tb_top;
    import mme_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int DIM           = 16;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int REPORT_CAP    = 30;

    typedef enum int { VAL_RANDOM, VAL_CORNER, VAL_MIN_ONLY } value_mode_t;

    // One element of C as it leaves the block
    typedef struct {
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [SUM_W-1:0] sum_value;
        logic             last;
    } c_elem_t;

    // Mirror of both element stores and the two registers; holds the C elements
    // still owed by the block, oldest first.
    class row_product_board;
        logic signed [ELEM_W-1:0] a_elem [DIM][DIM];
        logic signed [ELEM_W-1:0] b_elem [DIM][DIM];
        logic [CFG_W-1:0] inner_cfg;
        logic [CFG_W-1:0] cols_cfg;
        c_elem_t owed_q [$];
        int errors;

        function new();
            inner_cfg = 5'd16;
            cols_cfg  = 5'd16;
            errors    = 0;
            foreach (a_elem[i, j])
            begin
                a_elem[i][j] = '0;
                b_elem[i][j] = '0;
            end
        endfunction

        function void set_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            if (idx == CFG_INNER_LENGTH)
                inner_cfg = val;
            else
                cols_cfg = val;
        endfunction

        // Saturate the registers to the store dimensions
        function int eff_len();
            return (int'(inner_cfg) > DIM) ? DIM : int'(inner_cfg);
        endfunction

        function int eff_cols();
            return (int'(cols_cfg) > DIM) ? DIM : int'(cols_cfg);
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        // Apply one accepted request and queue the row of C it causes
        function void note_request(logic [FUNC_W-1:0] f, logic [IDX_W-1:0] r,
                                   logic [IDX_W-1:0] c, logic [ELEM_W-1:0] v);
            longint acc;
            int len;
            int ncols;
            c_elem_t item;
            len   = eff_len();
            ncols = eff_cols();
            if (f == FUNC_WRITE_A)
                a_elem[r][c] = v;
            else if (f == FUNC_WRITE_B)
                b_elem[r][c] = v;
            else if (f == FUNC_COMPUTE)
            begin
                for (int j = 0; j < ncols; j++)
                begin
                    acc = 0;
                    for (int k = 0; k < len; k++)
                        acc += longint'(a_elem[r][k]) * longint'(b_elem[k][j]);
                    item.row       = r;
                    item.col       = j[IDX_W-1:0];
                    item.sum_value = acc[SUM_W-1:0];
                    item.last      = (j == ncols - 1);
                    owed_q.push_back(item);
                end
            end
        endfunction

        function void report(string name, longint exp_v, longint act_v);
            errors++;
            if (errors <= REPORT_CAP)
                $error("%s: expected %0d, got %0d", name, exp_v, act_v);
        endfunction

        // Compare one result from the block with the oldest owed element
        function void check_result(logic [M_TDATA_W-1:0] data, logic last);
            c_elem_t exp_e;
            logic [IDX_W-1:0] row;
            logic [IDX_W-1:0] col;
            logic [SUM_W-1:0] sum;
            row = data[IDX_W-1:0];
            col = data[2*IDX_W-1:IDX_W];
            sum = data[2*IDX_W+SUM_W-1:2*IDX_W];
            if (owed_q.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_CAP)
                    $error("result with none owed: row %0d col %0d sum %0d",
                           row, col, $signed(sum));
                return;
            end
            exp_e = owed_q.pop_front();
            if (row != exp_e.row)
                report("out_row", longint'(exp_e.row), longint'(row));
            if (col != exp_e.col)
                report("out_col", longint'(exp_e.col), longint'(col));
            if (sum != exp_e.sum_value)
                report("sum_value", longint'($signed(exp_e.sum_value)),
                       longint'($signed(sum)));
            if (last != exp_e.last)
                report("last_of_row", longint'(exp_e.last), longint'(last));
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;   // row_index, col_index, element_value
    logic [FUNC_W-1:0]     s_tuser;   // func
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;   // out_row, out_col, sum_value, zero pad
    logic                  m_tlast;   // last_of_row
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]      cfg_data;

    row_product_board board;
    bit a_done [DIM][DIM];
    bit b_done [DIM][DIM];
    bit idle_on;
    bit pause_pending;
    int items_sent;
    int cycles;

    matrix_multiply_engine uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Check every result taken from the block
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_result(m_tdata, m_tlast);
    end

    // Receiver: ready, with random stall bursts while idling is on
    initial
    begin
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (idle_on && $urandom_range(0, 7) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    function automatic logic [ELEM_W-1:0] pick_value(value_mode_t mode);
        logic [ELEM_W-1:0] corners [5];
        corners = '{16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000, 16'h0001};
        if (mode == VAL_MIN_ONLY)
            return 16'h8000;
        if (mode == VAL_CORNER || $urandom_range(0, 9) == 0)
            return corners[$urandom_range(0, 4)];
        return ELEM_W'($urandom);
    endfunction

    // Present one request and hold it until accepted
    task automatic send_request(input logic [FUNC_W-1:0] f, input logic [IDX_W-1:0] r,
                                input logic [IDX_W-1:0] c, input logic [ELEM_W-1:0] v);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= {v, c, r};
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        board.note_request(f, r, c, v);
        if (f == FUNC_WRITE_A)
            a_done[r][c] = 1'b1;
        else if (f == FUNC_WRITE_B)
            b_done[r][c] = 1'b1;
        items_sent++;
    endtask

    task automatic drain_results();
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    // Drop valid, wait for every owed result, then let the block settle
    task automatic wait_quiet();
        s_tvalid <= 1'b0;
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write both registers on consecutive edges
    task automatic apply_config(input logic [CFG_W-1:0] inner_v,
                                input logic [CFG_W-1:0] cols_v);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_INNER_LENGTH;
        cfg_data  <= inner_v;
        @(posedge clk);
        board.set_config(CFG_INNER_LENGTH, inner_v);
        cfg_index <= CFG_OUTPUT_COLUMNS;
        cfg_data  <= cols_v;
        @(posedge clk);
        board.set_config(CFG_OUTPUT_COLUMNS, cols_v);
        cfg_wr_en <= 1'b0;
    endtask

    // Write every element a compute of row r will read that is still unset,
    // plus a few random rewrites (all of them when only minimum values are used)
    task automatic fill_row(input logic [IDX_W-1:0] r, input value_mode_t mode);
        int len;
        int nc;
        len = board.eff_len();
        nc  = board.eff_cols();
        for (int k = 0; k < len; k++)
            if (!a_done[r][k] || mode == VAL_MIN_ONLY || $urandom_range(0, 7) == 0)
                send_request(FUNC_WRITE_A, r, k[IDX_W-1:0], pick_value(mode));
        for (int k = 0; k < len; k++)
            for (int j = 0; j < nc; j++)
                if (!b_done[k][j] || mode == VAL_MIN_ONLY || $urandom_range(0, 7) == 0)
                    send_request(FUNC_WRITE_B, k[IDX_W-1:0], j[IDX_W-1:0],
                                 pick_value(mode));
    endtask

    // One setting of the registers followed by a mix of loads and computes
    task automatic run_phase(input int quota, input logic [CFG_W-1:0] inner_v,
                             input logic [CFG_W-1:0] cols_v, input value_mode_t mode);
        int start;
        int pick;
        logic [IDX_W-1:0] r;
        wait_quiet();
        apply_config(inner_v, cols_v);
        start = items_sent;
        while (items_sent - start < quota)
        begin
            pick = $urandom_range(0, 19);
            r    = IDX_W'($urandom_range(0, DIM - 1));
            if (pick < 9)
            begin
                fill_row(r, mode);
                send_request(FUNC_COMPUTE, r, IDX_W'($urandom), ELEM_W'($urandom));
            end
            else if (pick < 14)
                send_request(FUNC_WRITE_A, r, IDX_W'($urandom), pick_value(mode));
            else if (pick < 19)
                send_request(FUNC_WRITE_B, r, IDX_W'($urandom), pick_value(mode));
            else
                send_request(FUNC_UNUSED, r, IDX_W'($urandom), ELEM_W'($urandom));
            // hold the sender once until the block has caught up
            if (pause_pending && items_sent - start >= quota / 2)
            begin
                s_tvalid <= 1'b0;
                drain_results();
                pause_pending = 1'b0;
            end
        end
    endtask

    initial
    begin
        int shape;
        logic [CFG_W-1:0] inner_v;
        logic [CFG_W-1:0] cols_v;
        board         = new();
        idle_on       = 1'b1;
        pause_pending = 1'b0;
        items_sent    = 0;
        cycles        = 0;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extreme elements on a 2 x 2 product, ignored kind, index extremes
        apply_config(5'd2, 5'd2);
        send_request(FUNC_UNUSED, 4'hF, 4'hF, 16'hFFFF);
        send_request(FUNC_WRITE_A, 4'd0, 4'd0, 16'h8000);
        send_request(FUNC_WRITE_A, 4'd0, 4'd1, 16'h7FFF);
        send_request(FUNC_WRITE_B, 4'd0, 4'd0, 16'h8000);
        send_request(FUNC_WRITE_B, 4'd1, 4'd0, 16'h7FFF);
        send_request(FUNC_WRITE_B, 4'd0, 4'd1, 16'h7FFF);
        send_request(FUNC_WRITE_B, 4'd1, 4'd1, 16'h8000);
        send_request(FUNC_COMPUTE, 4'd0, 4'hF, 16'hFFFF);
        // an unused kind must leave the stores alone
        send_request(FUNC_UNUSED, 4'd0, 4'd0, 16'h0000);
        send_request(FUNC_COMPUTE, 4'd0, 4'd0, 16'h0000);
        send_request(FUNC_WRITE_A, 4'hF, 4'hF, 16'hFFFF);
        send_request(FUNC_WRITE_B, 4'hF, 4'hF, 16'h0001);
        // zero inner length gives zero sums
        wait_quiet();
        apply_config(5'd0, 5'd2);
        send_request(FUNC_COMPUTE, 4'd7, 4'd3, 16'h1234);
        // zero columns emit nothing
        wait_quiet();
        apply_config(5'd2, 5'd0);
        send_request(FUNC_COMPUTE, 4'd0, 4'd0, 16'h0000);

        // Register extremes, with saturation above the store size
        run_phase(40, 5'd31, 5'd1, VAL_MIN_ONLY);
        run_phase(40, 5'd1, 5'd31, VAL_CORNER);
        run_phase(10, 5'd0, 5'd31, VAL_RANDOM);
        run_phase(10, 5'd31, 5'd0, VAL_RANDOM);

        // Random phases, mostly small sizes
        pause_pending = 1'b1;
        while (items_sent < 280)
        begin
            shape = $urandom_range(0, 9);
            if (shape == 0)
            begin
                inner_v = CFG_W'($urandom_range(16, 31));
                cols_v  = CFG_W'($urandom_range(1, 2));
            end
            else if (shape == 1)
            begin
                inner_v = CFG_W'($urandom_range(1, 2));
                cols_v  = CFG_W'($urandom_range(16, 31));
            end
            else
            begin
                inner_v = CFG_W'($urandom_range(0, 5));
                cols_v  = CFG_W'($urandom_range(0, 5));
            end
            run_phase(25, inner_v, cols_v, value_mode_t'($urandom_range(0, 1)));
        end

        // Last stretch at full rate on both sides
        idle_on = 1'b0;
        run_phase(40, 5'd3, 5'd4, VAL_RANDOM);

        s_tvalid <= 1'b0;
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
